[rtl/aput_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aput_pkg
// Shared types and constants of the address pool utilization tracker.
// ----------------------------------------------------------------------------
package aput_pkg;

  localparam int unsigned KIND_W     = 8;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned CFG_SLOTS  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [KIND_W-1:0]    ACK_KIND  = 8'd5;
  localparam logic [COUNT_W-1:0]   COUNT_MAX = 10'h3FF;

  // register indexes: bases first, then lengths
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEN0  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] message_kind;
    logic [ADDR_W-1:0] client_addr;
  } in_item_t;

  typedef struct packed {
    logic [CFG_SLOTS-1:0] hit_mask;
    logic [CFG_SLOTS-1:0] counted_mask;
    logic [CFG_SLOTS-1:0] half_full_mask;
    logic [COUNT_W-1:0]   count_slot0;
    logic [COUNT_W-1:0]   count_slot1;
    logic [COUNT_W-1:0]   count_slot2;
    logic [COUNT_W-1:0]   count_slot3;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/aput_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aput_ctrl
// Sequencer: bitmap clearing pass after reset, then accept and update per item.
// ----------------------------------------------------------------------------
module aput_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire aput_pkg::dp_status_t   status,
  output aput_pkg::ctrl_cmd_t         cmd,
  output logic                        busy
);
  import aput_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/aput_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aput_dp
// Datapath: prefix registers, prefix match, per-slot seen bitmaps and counts.
// ----------------------------------------------------------------------------
module aput_dp #(
  parameter int unsigned PREFIX_SLOTS = 4,
  parameter int unsigned HOST_BITS    = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire aput_pkg::ctrl_cmd_t                cmd,
  output aput_pkg::dp_status_t                    status,
  input  wire aput_pkg::in_item_t                 in_item,
  input  wire logic                               cfg_we,
  input  wire logic [aput_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [aput_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                    out_valid,
  output aput_pkg::out_item_t                     out_item
);
  import aput_pkg::*;

  localparam int unsigned ACT_SLOTS = (PREFIX_SLOTS < CFG_SLOTS) ? PREFIX_SLOTS : CFG_SLOTS;
  localparam int unsigned CMP_W     = (HOST_BITS > COUNT_W + 1) ? HOST_BITS : COUNT_W + 1;
  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(32 - HOST_BITS);

  logic [HOST_BITS-1:0] clr_addr_r;
  logic                 is_ack;
  logic [CFG_SLOTS-1:0] hit_v;
  logic [CFG_SLOTS-1:0] new_v;
  logic [CFG_SLOTS-1:0] half_v;
  logic [COUNT_W-1:0]   cnt_v [CFG_SLOTS];
  logic                 out_valid_r;
  out_item_t            out_item_r;

  assign is_ack = (in_item.message_kind == ACK_KIND) && (in_item.client_addr != '0);

  // clearing pass walks all offsets of every bank at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign status.clear_last = &clr_addr_r;

  for (genvar s = 0; s < CFG_SLOTS; s++) begin : g_slot
    if (s < ACT_SLOTS) begin : g_act
      logic [ADDR_W-1:0]    base_r;
      logic [LEN_W-1:0]     len_r;
      logic [COUNT_W-1:0]   host_count_r;
      logic                 hit_r;
      logic [HOST_BITS-1:0] off_r;
      logic                 seen_q_r;
      logic                 seen_mem [2**HOST_BITS];
      logic [ADDR_W-1:0]    hmask;
      logic [HOST_BITS-1:0] off_in;
      logic                 hit_in;
      logic [HOST_BITS-1:0] cap;
      logic [COUNT_W-1:0]   cnt_inc;
      logic                 is_new;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          base_r <= '0;
          len_r  <= '0;
        end else if (cfg_we) begin
          if (cfg_index == CFG_IDX_BASE0 + CFG_IDX_W'(s)) begin
            base_r <= cfg_data;
          end
          if (cfg_index == CFG_IDX_LEN0 + CFG_IDX_W'(s)) begin
            len_r <= cfg_data[LEN_W-1:0];
          end
        end
      end

      // host mask; only lengths of at least 32-HOST_BITS enable the slot
      assign hmask  = {ADDR_W{1'b1}} >> len_r;
      assign off_in = in_item.client_addr[HOST_BITS-1:0] & hmask[HOST_BITS-1:0];
      assign hit_in = is_ack && (len_r != '0) && (len_r >= MIN_LEN)
                   && (((in_item.client_addr ^ base_r) & ~hmask) == '0)
                   && (off_in != '0) && (off_in != hmask[HOST_BITS-1:0]);

      always_ff @(posedge clk) begin
        if (cmd.accept) begin
          hit_r <= hit_in;
          off_r <= off_in;
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.clr_en) begin
          seen_mem[clr_addr_r] <= 1'b0;
        end else if (cmd.update && is_new) begin
          seen_mem[off_r] <= 1'b1;
        end
        if (cmd.accept) begin
          seen_q_r <= seen_mem[off_in];
        end
      end

      assign is_new  = hit_r && !seen_q_r;
      assign cap     = hmask[HOST_BITS-1:0] - 1'b1;
      assign cnt_inc = (host_count_r == COUNT_MAX) ? host_count_r : host_count_r + 1'b1;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          host_count_r <= '0;
        end else if (cmd.update && is_new) begin
          host_count_r <= cnt_inc;
        end
      end

      // half full: 2*count crosses the capacity on this item
      assign half_v[s] = is_new
                      && (CMP_W'({host_count_r, 1'b0}) < CMP_W'(cap))
                      && (CMP_W'({cnt_inc, 1'b0}) >= CMP_W'(cap));
      assign hit_v[s]  = hit_r;
      assign new_v[s]  = is_new;
      assign cnt_v[s]  = is_new ? cnt_inc : host_count_r;
    end else begin : g_off
      assign hit_v[s]  = 1'b0;
      assign new_v[s]  = 1'b0;
      assign half_v[s] = 1'b0;
      assign cnt_v[s]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_item_r.hit_mask       <= hit_v;
      out_item_r.counted_mask   <= new_v;
      out_item_r.half_full_mask <= half_v;
      out_item_r.count_slot0    <= cnt_v[0];
      out_item_r.count_slot1    <= cnt_v[1];
      out_item_r.count_slot2    <= cnt_v[2];
      out_item_r.count_slot3    <= cnt_v[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

[rtl/address_pool_utilization_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// address_pool_utilization_tracker
// Counts distinct leased IPv4 addresses per configured prefix slot.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The prefix match and
// the read of each slot's seen bitmap happen at the accepting edge, the next
// cycle writes the bitmap and counts, and the result is on out_item with
// out_valid for exactly one cycle after that. No item is taken in the update
// cycle; the next can be started in the cycle the result shows. Each slot's
// bitmap bank is read at acceptance and written at update. The result cannot
// be held off and must be taken when out_valid is high. After reset busy is
// high while the bitmaps are cleared. Configuration writes belong to when no
// item is in flight only; the user must see to it, the block does not enforce it.
// ----------------------------------------------------------------------------
module address_pool_utilization_tracker #(
  parameter int unsigned PREFIX_SLOTS = 4,
  parameter int unsigned HOST_BITS    = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire aput_pkg::in_item_t                 in_item,
  output logic                                    out_valid,
  output aput_pkg::out_item_t                     out_item,
  input  wire logic                               cfg_we,
  input  wire logic [aput_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [aput_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import aput_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  aput_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  aput_dp #(
    .PREFIX_SLOTS (PREFIX_SLOTS),
    .HOST_BITS    (HOST_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

[rtl/aput_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aput_chk
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module aput_chk (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire aput_pkg::out_item_t  out_item
);
  import aput_pkg::*;

  // an accepted item keeps the block busy for its update cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("no update cycle after accepted item");

  // result shows right after the update cycle, with the block free again
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobe out of place");

  a_counted_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.counted_mask & ~out_item.hit_mask) == '0)
    else $error("counted slot without hit");

  a_half_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.half_full_mask & ~out_item.counted_mask) == '0)
    else $error("half full notice without new address");

endmodule

bind address_pool_utilization_tracker aput_chk u_chk (.*);
`default_nettype wire

[verif/tb_address_pool_utilization_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_address_pool_utilization_tracker
// Drives DHCP message items into the tracker under several prefix setups,
// predicts hit, new-lease and half-full masks plus slot counts, and checks
// every result in order against that prediction.
// ----------------------------------------------------------------------------
module tb_address_pool_utilization_tracker;
  import aput_pkg::*;

  localparam int unsigned HOST_BITS  = 10;
  localparam int unsigned MIN_LEN    = 32 - HOST_BITS;
  localparam int unsigned IDLE_LIMIT = 4000;

  // lease tracker shadow and in-order result checker
  class lease_scoreboard;
    bit [ADDR_W-1:0] slot_base [CFG_SLOTS];
    bit [LEN_W-1:0]  slot_len  [CFG_SLOTS];
    bit              seen      [CFG_SLOTS][1 << HOST_BITS];
    int unsigned     tally     [CFG_SLOTS];
    out_item_t       pending[$];
    int unsigned     fault_count;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx < CFG_IDX_LEN0) slot_base[idx - CFG_IDX_BASE0] = data;
      else slot_len[idx - CFG_IDX_LEN0] = data[LEN_W-1:0];
    endfunction

    function out_item_t predict_lease(in_item_t it);
      out_item_t   res;
      int unsigned hm, off, cap, prior;
      res = '0;
      if (it.message_kind == ACK_KIND && it.client_addr != 0) begin
        for (int s = 0; s < CFG_SLOTS; s++) begin
          if (slot_len[s] == 0 || slot_len[s] < MIN_LEN) continue;
          hm = (32'd1 << (32 - slot_len[s])) - 1;
          if ((it.client_addr & ~hm) != (slot_base[s] & ~hm)) continue;
          off = it.client_addr & hm;
          // network and broadcast offsets never count
          if (off == 0 || off >= hm) continue;
          res.hit_mask[s] = 1'b1;
          if (seen[s][off]) continue;
          seen[s][off] = 1'b1;
          res.counted_mask[s] = 1'b1;
          cap   = hm - 1;
          prior = tally[s];
          if (tally[s] < COUNT_MAX) tally[s]++;
          if (2 * prior < cap && 2 * tally[s] >= cap) res.half_full_mask[s] = 1'b1;
        end
      end
      res.count_slot0 = COUNT_W'(tally[0]);
      res.count_slot1 = COUNT_W'(tally[1]);
      res.count_slot2 = COUNT_W'(tally[2]);
      res.count_slot3 = COUNT_W'(tally[3]);
      return res;
    endfunction

    function void note_item(in_item_t it);
      pending.insert(pending.size(), predict_lease(it));
    endfunction

    function void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got)
        note_fault($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        note_fault("result with no item outstanding");
        return;
      end
      want = pending.pop_front();
      compare_field("hit_mask", want.hit_mask, got.hit_mask);
      compare_field("counted_mask", want.counted_mask, got.counted_mask);
      compare_field("half_full_mask", want.half_full_mask, got.half_full_mask);
      compare_field("count_slot0", want.count_slot0, got.count_slot0);
      compare_field("count_slot1", want.count_slot1, got.count_slot1);
      compare_field("count_slot2", want.count_slot2, got.count_slot2);
      compare_field("count_slot3", want.count_slot3, got.count_slot3);
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  lease_scoreboard sb;
  int unsigned     idle_cycles = 0;

  // what the stimulus last programmed, used to aim addresses at prefixes
  bit [31:0] cur_base [CFG_SLOTS];
  bit [4:0]  cur_len  [CFG_SLOTS];
  bit [31:0] cursor   [CFG_SLOTS];

  address_pool_utilization_tracker #(
    .PREFIX_SLOTS(4),
    .HOST_BITS   (HOST_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && busy === 1'b0) sb.note_item(in_item);
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (out_valid || (start && busy === 1'b0) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic in_item_t msg(bit [7:0] kind, bit [31:0] addr);
    in_item_t it;
    it.message_kind = kind;
    it.client_addr  = addr;
    return it;
  endfunction

  task automatic send_item(in_item_t it, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_slot(int s, bit [31:0] b, bit [4:0] l);
    bit [31:0] len_word;
    len_word      = $urandom();
    // upper bits of a length write are don't-care
    len_word[4:0] = l;
    write_reg(CFG_IDX_W'(CFG_IDX_BASE0 + s), b);
    write_reg(CFG_IDX_W'(CFG_IDX_LEN0 + s), len_word);
    cur_base[s] = b;
    cur_len[s]  = l;
    cursor[s]   = 1;
  endtask

  function automatic int pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly leases walking through a prefix, some random hosts, some noise
  function automatic in_item_t make_item(int focus);
    in_item_t    it;
    int          s;
    int unsigned r;
    bit [31:0]   hm;
    r = $urandom_range(0, 99);
    it.message_kind = ACK_KIND;
    if (r < 85) begin
      s  = (focus >= 0) ? focus : $urandom_range(0, CFG_SLOTS - 1);
      hm = 32'((64'd1 << (32 - cur_len[s])) - 64'd1);
      if ($urandom_range(0, 4) != 0) begin
        it.client_addr = (cur_base[s] & ~hm) | cursor[s];
        cursor[s] = (cursor[s] + 1 >= hm) ? 32'd1 : cursor[s] + 1;
      end else begin
        it.client_addr = (cur_base[s] & ~hm) | ($urandom() & hm);
      end
    end else if (r < 90) begin
      it.client_addr = '0;
    end else if (r < 95) begin
      it.client_addr = $urandom();
    end else begin
      it.message_kind = 8'($urandom_range(0, 255));
      it.client_addr  = $urandom();
    end
    return it;
  endfunction

  initial begin
    bit [31:0] probes[$];
    int        n;
    bit        steady;
    bit [4:0]  l;
    bit [31:0] b;
    int unsigned r;

    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    // bitmap clearing pass after reset
    do @(posedge clk); while (busy !== 1'b0);

    // every slot disabled out of reset
    send_item(msg(ACK_KIND, 32'h0A00_0001), 0);
    send_item(msg(8'h00, 32'hFFFF_FFFF), 0);
    send_item(msg(8'hFF, 32'h0A00_0001), 1);
    send_item(msg(ACK_KIND, 32'h0), 0);

    wait_for_results();
    // host bits of the slot 0 base are ignored; slot 1 sits inside slot 0
    program_slot(0, 32'h0A00_03FF, 5'd22);
    program_slot(1, 32'h0A00_0004, 5'd30);
    program_slot(2, 32'hC0A8_0100, 5'd31);
    program_slot(3, 32'hFFFF_FFF8, 5'd29);

    probes = {32'h0A00_0005, 32'h0A00_0005, 32'h0A00_0006, 32'h0A00_0004,
              32'h0A00_0007, 32'h0A00_0000, 32'h0A00_03FF, 32'h0A00_0001,
              32'h0A00_03FE, 32'hFFFF_FFF9, 32'hFFFF_FFFA, 32'hFFFF_FFFB,
              32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'hC0A8_0100, 32'hC0A8_0101};
    foreach (probes[i]) send_item(msg(ACK_KIND, probes[i]), i % 3);
    send_item(msg(8'h04, 32'h0A00_0010), 0);
    send_item(msg(8'h85, 32'h0A00_0011), 0);
    send_item(msg(ACK_KIND, 32'h0), 2);

    for (int ph = 0; ph < 6; ph++) begin
      wait_for_results();
      if (ph == 0) begin
        // one wide slot filled past half, the rest kept from hitting in each way
        program_slot(0, 32'h0A00_0000, 5'd22);
        program_slot(1, $urandom(), 5'd0);
        program_slot(2, $urandom(), 5'd21);
        program_slot(3, $urandom(), 5'd31);
      end else if (ph == 5) begin
        program_slot(0, 32'hFFFF_FFFF, 5'd22);
        program_slot(1, 32'h0000_0000, 5'd22);
        program_slot(2, 32'hFFFF_FFFF, 5'd31);
        program_slot(3, 32'h0000_0000, 5'd30);
      end else begin
        for (int s = 0; s < CFG_SLOTS; s++) begin
          r = $urandom_range(0, 9);
          if (r == 0) l = 5'd0;
          else if (r == 1) l = 5'($urandom_range(1, MIN_LEN - 1));
          else l = 5'($urandom_range(MIN_LEN, 31));
          // a random half of the slots take a base near slot 0 to get multi-slot hits
          b = $urandom_range(0, 1) ? $urandom() : cur_base[0] ^ $urandom_range(0, 4095);
          program_slot(s, b, l);
        end
      end
      n      = (ph == 0) ? 800 : 85;
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
        if (!steady && $urandom_range(0, 49) == 0) wait_for_results();
        send_item(make_item((ph == 0) ? 0 : -1), pick_gap(steady));
      end
    end

    wait_for_results();
    repeat (6) @(posedge clk);
    if (sb.fault_count == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
